/* design/cfs_pkg.sv */
package cfs_pkg;

    // Depth of the trailing whitespace buffer.
    localparam int SPACE_DEPTH = 32;
    localparam int SP_AW = (SPACE_DEPTH > 1) ? $clog2(SPACE_DEPTH) : 1;
    localparam int SP_CW = $clog2(SPACE_DEPTH + 1);
    localparam int SP_SW = SP_CW + 1;

    localparam int CH_W   = 16;
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef logic [CH_W-1:0] t_char;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_FIELD = 2'd1;
    localparam logic [1:0] KIND_ROW   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_DELIMITER = 3'd0;
    localparam logic [2:0] REG_QUOTE     = 3'd1;
    localparam logic [2:0] REG_ROW_TERM  = 3'd2;
    localparam logic [2:0] REG_ALT_FIRST = 3'd3;
    localparam logic [2:0] REG_ALT_SEC   = 3'd4;
    localparam logic [2:0] REG_ALT_EN    = 3'd5;
    localparam logic [2:0] REG_TRIM      = 3'd6;

    // What one character does when it is processed.
    typedef enum logic [1:0] {
        ACT_TOGGLE,
        ACT_APPEND,
        ACT_END_FIELD,
        ACT_END_ROW
    } t_act;

    typedef struct packed {
        logic       load_in;
        logic       la_load;
        logic       la_clear;
        logic       proc;
        logic       set_content;
        logic       emit_quote;
        logic       emit_buf;
        logic       push_ws;
        logic       char_op;
        logic       end_mark;
        logic [1:0] end_kind;
        logic       clear_stream;
        logic       close;
        logic       virt_next;
    } t_cmd;

    typedef struct packed {
        logic disabled;
        logic la_valid;
        logic last;
        t_act act;
        logic consumed;
        logic trim_ws;
        logic nonspace;
        logic held;
        logic hold_char;
        logic count_zero;
        logic count_one;
        logic count_full;
        logic can_emit;
        logic pend_valid;
        logic fend_needed;
    } t_sts;

    function automatic logic is_ws(input t_char c);
        is_ws = (c >= 16'd9 && c <= 16'd13) || c == 16'd32 || c == 16'h0085 ||
                c == 16'h00A0 || c == 16'h1680 ||
                (c >= 16'h2000 && c <= 16'h200A) || c == 16'h2028 ||
                c == 16'h2029 || c == 16'h202F || c == 16'h205F || c == 16'h3000;
    endfunction

endpackage

/* design/cfs_dpath.sv */
module cfs_dpath import cfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [CH_W-1:0]   i_ch,
    input  logic              i_last_in_source,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [1:0]        o_kind,
    output logic [CH_W-1:0]   o_value_char,
    output logic              o_last_of_run,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_char r_delim, r_quote, r_rowterm, r_alt1, r_alt2;
    logic  r_alt_en, r_trim;

    t_char r_cur;
    logic  r_last;
    t_char r_la;
    logic  r_la_valid, r_in_quotes, r_content, r_nonspace, r_held, r_last_delim;

    logic [SP_AW-1:0] r_head;
    logic [SP_CW-1:0] r_count;
    t_char            r_space_mem [SPACE_DEPTH];
    t_char            r_space_rd;

    logic       r_pend_valid;
    logic [1:0] r_pend_kind;
    t_char      r_pend_char;
    logic       r_out_valid, r_out_last;
    logic [1:0] r_out_kind;
    t_char      r_out_char;

    t_char            first, second;
    t_act             act;
    logic             consumed;
    logic             hold_char;
    logic [SP_SW-1:0] tail_sum;
    logic [SP_AW-1:0] tail;
    logic [SP_AW-1:0] n_head;
    logic             can_emit;
    logic             e_valid;
    logic [1:0]       e_kind;
    t_char            e_char;
    logic             move_out;
    logic             cfg_wr;
    logic [2:0]       cfg_idx;

    assign first  = r_la;
    assign second = i_cmd.virt_next ? '0 : r_cur;

    // Quote test first, then delimiter, then the two terminators.
    always_comb begin
        act      = ACT_APPEND;
        consumed = 1'b0;
        if (first == r_quote) begin
            if (second == r_quote) begin
                act      = ACT_APPEND;
                consumed = 1'b1;
            end else begin
                act = ACT_TOGGLE;
            end
        end else if (r_in_quotes) begin
            act = ACT_APPEND;
        end else if (first == r_delim) begin
            act = ACT_END_FIELD;
        end else if (r_rowterm != '0 && first == r_rowterm) begin
            act = ACT_END_ROW;
        end else if (r_alt_en && first == r_alt1 && second == r_alt2) begin
            act      = ACT_END_ROW;
            consumed = 1'b1;
        end
    end

    assign hold_char = !r_nonspace && (first == r_quote);

    // The whitespace buffer is a ring; the tail lies count entries past the head.
    always_comb begin
        tail_sum = SP_SW'(r_head) + SP_SW'(r_count);
        if (tail_sum >= SP_SW'(SPACE_DEPTH)) begin
            tail_sum = tail_sum - SP_SW'(SPACE_DEPTH);
        end
        tail = tail_sum[SP_AW-1:0];
    end

    assign n_head = (r_head == SP_AW'(SPACE_DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign can_emit = !r_pend_valid || !r_out_valid || i_ready;

    assign e_valid = i_cmd.emit_quote || i_cmd.emit_buf || i_cmd.end_mark ||
                     (i_cmd.char_op && !hold_char);
    assign e_kind  = i_cmd.end_mark ? i_cmd.end_kind : KIND_CHAR;

    always_comb begin
        if (i_cmd.emit_quote) begin
            e_char = r_quote;
        end else if (i_cmd.emit_buf) begin
            e_char = r_space_rd;
        end else if (i_cmd.end_mark) begin
            e_char = '0;
        end else begin
            e_char = first;
        end
    end

    always_comb begin
        o_sts             = '0;
        o_sts.disabled    = (r_delim == '0) || (r_rowterm == '0 && !r_alt_en);
        o_sts.la_valid    = r_la_valid;
        o_sts.last        = r_last;
        o_sts.act         = act;
        o_sts.consumed    = consumed;
        o_sts.trim_ws     = r_trim && is_ws(first);
        o_sts.nonspace    = r_nonspace;
        o_sts.held        = r_held;
        o_sts.hold_char   = hold_char;
        o_sts.count_zero  = (r_count == '0);
        o_sts.count_one   = (r_count == SP_CW'(1));
        o_sts.count_full  = (r_count == SP_CW'(SPACE_DEPTH));
        o_sts.can_emit    = can_emit;
        o_sts.pend_valid  = r_pend_valid;
        o_sts.fend_needed = r_content || r_in_quotes || r_last_delim;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cur  <= i_ch;
            r_last <= i_last_in_source;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la         <= '0;
            r_la_valid   <= 1'b0;
            r_in_quotes  <= 1'b0;
            r_content    <= 1'b0;
            r_nonspace   <= 1'b0;
            r_held       <= 1'b0;
            r_last_delim <= 1'b0;
            r_head       <= '0;
            r_count      <= '0;
        end else begin
            if (i_cmd.la_load) begin
                r_la       <= r_cur;
                r_la_valid <= 1'b1;
            end
            if (i_cmd.la_clear) begin
                r_la_valid <= 1'b0;
            end
            if (i_cmd.proc) begin
                r_last_delim <= (first == r_delim);
                if (act == ACT_TOGGLE) begin
                    r_in_quotes <= !r_in_quotes;
                end
            end
            if (i_cmd.set_content) begin
                r_content <= 1'b1;
            end
            if (i_cmd.emit_quote) begin
                r_held <= 1'b0;
            end
            if (i_cmd.emit_buf) begin
                r_head  <= n_head;
                r_count <= r_count - 1'b1;
            end
            if (i_cmd.push_ws) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.char_op) begin
                if (hold_char) begin
                    r_held <= 1'b1;
                end
                r_nonspace <= 1'b1;
            end
            if (i_cmd.end_mark) begin
                r_count    <= '0;
                r_held     <= 1'b0;
                r_content  <= 1'b0;
                r_nonspace <= 1'b0;
            end
            if (i_cmd.clear_stream) begin
                r_la         <= '0;
                r_la_valid   <= 1'b0;
                r_in_quotes  <= 1'b0;
                r_content    <= 1'b0;
                r_nonspace   <= 1'b0;
                r_held       <= 1'b0;
                r_last_delim <= 1'b0;
                r_count      <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_ws) begin
            r_space_mem[tail] <= first;
        end
        r_space_rd <= r_space_mem[r_head];
    end

    // Each new result waits in the pending stage, so the one before it can be
    // released with its end-of-run flag known.
    assign move_out = r_pend_valid && (e_valid || i_cmd.close);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (move_out) begin
                r_out_valid <= 1'b1;
                r_out_kind  <= r_pend_kind;
                r_out_char  <= r_pend_char;
                r_out_last  <= !e_valid;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (e_valid) begin
                r_pend_valid <= 1'b1;
                r_pend_kind  <= e_kind;
                r_pend_char  <= e_char;
            end else if (i_cmd.close) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_kind        = r_out_kind;
    assign o_value_char  = r_out_char;
    assign o_last_of_run = r_out_last;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim   <= 16'd44;
            r_quote   <= 16'd34;
            r_rowterm <= 16'd10;
            r_alt1    <= 16'd13;
            r_alt2    <= 16'd10;
            r_alt_en  <= 1'b1;
            r_trim    <= 1'b0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_DELIMITER: r_delim   <= pwdata[CH_W-1:0];
                REG_QUOTE:     r_quote   <= pwdata[CH_W-1:0];
                REG_ROW_TERM:  r_rowterm <= pwdata[CH_W-1:0];
                REG_ALT_FIRST: r_alt1    <= pwdata[CH_W-1:0];
                REG_ALT_SEC:   r_alt2    <= pwdata[CH_W-1:0];
                REG_ALT_EN:    r_alt_en  <= pwdata[0];
                REG_TRIM:      r_trim    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_DELIMITER: prdata = APB_DW'(r_delim);
            REG_QUOTE:     prdata = APB_DW'(r_quote);
            REG_ROW_TERM:  prdata = APB_DW'(r_rowterm);
            REG_ALT_FIRST: prdata = APB_DW'(r_alt1);
            REG_ALT_SEC:   prdata = APB_DW'(r_alt2);
            REG_ALT_EN:    prdata = APB_DW'(r_alt_en);
            REG_TRIM:      prdata = APB_DW'(r_trim);
            default:       prdata = '0;
        endcase
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SP_CW'(SPACE_DEPTH))
        else $error("whitespace count above buffer depth");

    a_held_nonspace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> r_nonspace)
        else $error("held quote without a value character");

    a_ws_nonspace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) |-> r_nonspace)
        else $error("trailing whitespace buffered before any value character");

endmodule

/* design/cfs_ctrl.sv */
module cfs_ctrl import cfs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_PROC,
        S_AP,
        S_REL,
        S_RD,
        S_EM,
        S_WR,
        S_CHAR,
        S_END,
        S_POST,
        S_LASTCHK,
        S_FEND,
        S_CLEAR,
        S_CLOSE
    } t_state;

    t_state r_state, n_state;
    logic   r_ovf, n_ovf;
    logic   r_final, n_final;
    logic   r_fend, n_fend;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state         = r_state;
        n_ovf           = r_ovf;
        n_final         = r_final;
        n_fend          = r_fend;
        o_cmd           = '0;
        o_cmd.virt_next = r_final;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (!i_sts.disabled) begin
                        n_state = S_START;
                    end
                end
            end
            S_START: begin
                n_final = 1'b0;
                if (!i_sts.la_valid) begin
                    o_cmd.la_load = 1'b1;
                    n_state       = S_LASTCHK;
                end else begin
                    n_state = S_PROC;
                end
            end
            S_PROC: begin
                o_cmd.proc = 1'b1;
                case (i_sts.act)
                    ACT_TOGGLE: n_state = S_POST;
                    ACT_APPEND: n_state = S_AP;
                    default:    n_state = S_END;
                endcase
            end
            S_AP: begin
                o_cmd.set_content = 1'b1;
                if (i_sts.trim_ws) begin
                    if (!i_sts.nonspace) begin
                        n_state = S_POST;
                    end else if (i_sts.count_full) begin
                        // Buffer overflow: the oldest space joins the value.
                        n_ovf   = 1'b1;
                        n_state = S_REL;
                    end else begin
                        n_state = S_WR;
                    end
                end else begin
                    n_ovf   = 1'b0;
                    n_state = S_REL;
                end
            end
            S_REL: begin
                if (!i_sts.held || i_sts.can_emit) begin
                    o_cmd.emit_quote = i_sts.held;
                    n_state = (r_ovf || !i_sts.count_zero) ? S_RD : S_CHAR;
                end
            end
            S_RD: begin
                n_state = S_EM;
            end
            S_EM: begin
                if (i_sts.can_emit) begin
                    o_cmd.emit_buf = 1'b1;
                    if (r_ovf) begin
                        n_state = S_WR;
                    end else begin
                        n_state = i_sts.count_one ? S_CHAR : S_RD;
                    end
                end
            end
            S_WR: begin
                o_cmd.push_ws = 1'b1;
                n_state       = S_POST;
            end
            S_CHAR: begin
                if (i_sts.hold_char || i_sts.can_emit) begin
                    o_cmd.char_op = 1'b1;
                    n_state       = S_POST;
                end
            end
            S_END: begin
                if (i_sts.can_emit) begin
                    o_cmd.end_mark = 1'b1;
                    if (r_fend || i_sts.act != ACT_END_FIELD) begin
                        o_cmd.end_kind = KIND_ROW;
                    end else begin
                        o_cmd.end_kind = KIND_FIELD;
                    end
                    n_state = r_fend ? S_CLEAR : S_POST;
                end
            end
            S_POST: begin
                if (r_final) begin
                    n_state = S_FEND;
                end else begin
                    if (i_sts.consumed) begin
                        o_cmd.la_clear = 1'b1;
                    end else begin
                        o_cmd.la_load = 1'b1;
                    end
                    n_state = S_LASTCHK;
                end
            end
            S_LASTCHK: begin
                if (!i_sts.last) begin
                    n_state = S_CLOSE;
                end else if (i_sts.la_valid) begin
                    // The held character is processed against a zero.
                    n_final = 1'b1;
                    n_state = S_PROC;
                end else begin
                    n_state = S_FEND;
                end
            end
            S_FEND: begin
                if (i_sts.fend_needed) begin
                    n_fend  = 1'b1;
                    n_state = S_END;
                end else begin
                    n_state = S_CLEAR;
                end
            end
            S_CLEAR: begin
                o_cmd.clear_stream = 1'b1;
                n_fend             = 1'b0;
                n_final            = 1'b0;
                n_state            = S_CLOSE;
            end
            S_CLOSE: begin
                if (i_sts.can_emit) begin
                    o_cmd.close = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovf   <= 1'b0;
            r_final <= 1'b0;
            r_fend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
            r_final <= n_final;
            r_fend  <= n_fend;
        end
    end

    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !i_sts.pend_valid)
        else $error("pending result left behind at the end of a transfer");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit_buf || o_cmd.end_mark || o_cmd.emit_quote || o_cmd.close)
        |-> i_sts.can_emit)
        else $error("result issued while the output stage is full");

endmodule

/* design/csv_field_splitter.sv */
// Streaming splitter for delimited text with quoted fields.
// Input channel (i_valid / o_ready): one 16-bit character per transfer, with
// i_last_in_source marking the final character of a source. Output channel
// (o_valid / i_ready): value characters, end-of-field and end-of-row marks;
// o_last_of_run is set on the final result caused by an input transfer.
// The user must write registers over the APB port only while the block is
// idle; the block itself does not enforce this. One character is held back
// as lookahead, so a character's results appear when the next character
// arrives, or at the end of the source. After acceptance an input character
// keeps o_ready low while it is processed; every buffered trailing space that
// is released passes a read state and an emit state, since it is read from
// the whitespace memory with a registered read. The last character of a
// source also brings the processing of the held character and any final mark.
// Results pass through a pending stage and an output register, so a stalled
// receiver only holds the sequencer at its next result; o_ready is low from
// acceptance until all results of that character sit in those two stages.
// Reset restores the register defaults and empties lookahead, quote and
// field state; the whitespace memory is not cleared.
module csv_field_splitter import cfs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [CH_W-1:0]   i_ch,
    input  logic              i_last_in_source,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [CH_W-1:0]   o_value_char,
    output logic              o_last_of_run,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cmd cmd;
    t_sts sts;

    cfs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    cfs_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_ch             (i_ch),
        .i_last_in_source (i_last_in_source),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_value_char     (o_value_char),
        .o_last_of_run    (o_last_of_run),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

endmodule
